[src/color_key_bounding_box_top_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the colour-key bounding box block.
// ---------------------------------------------------------------------------
`ifndef COLOR_KEY_BOUNDING_BOX_TOP_DEFINES_SVH
`define COLOR_KEY_BOUNDING_BOX_TOP_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define CKBB_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define CKBB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/ckbb_pkg.sv]
// ---------------------------------------------------------------------------
// Colour-key bounding box package
// Widths, register indexes and the result item type.
// ---------------------------------------------------------------------------
package ckbb_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   localparam int COMP_W  = 8;
   localparam int SIZE_W  = 12;
   localparam int COORD_W = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_PAD_W  = RSP_DATA_W - 3 * COMP_W - 4 * COORD_W;

   localparam logic [COMP_W-1:0] BLUE_BELOW_RESET  = 8'd100;
   localparam logic [COMP_W-1:0] GREEN_ABOVE_RESET = 8'd130;
   localparam logic [COMP_W-1:0] RED_ABOVE_RESET   = 8'd170;
   localparam logic [SIZE_W-1:0] WIDTH_RESET       = 12'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET      = 12'd480;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BLUE_BELOW   = 3'd0,
      REG_GREEN_ABOVE  = 3'd1,
      REG_RED_ABOVE    = 3'd2,
      REG_FRAME_WIDTH  = 3'd3,
      REG_FRAME_HEIGHT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] span_y;
      logic [COORD_W-1:0] span_x;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] left;
      logic               found;
      logic               done;
      logic [COMP_W-1:0]  red;
      logic [COMP_W-1:0]  green;
      logic [COMP_W-1:0]  blue;
   } rsp_item_type;

endpackage

[src/color_key_bounding_box_top.sv]
// ---------------------------------------------------------------------------
// Colour-key bounding box
// Blanks key-coloured pixels and reports the box around them once a frame.
// ---------------------------------------------------------------------------
//  channel | direction | transfer contents
//  req_    | in        | one BGR pixel, raster order
//  rsp_    | out       | pixel out; box report with tlast on the frame's last pixel
//  csr_    | in        | register write, index and data, no read-back
//
//  One pixel per clock while the skid stage is not full; each result is registered before it leaves.
//  The throughput is set by the single compare and min/max update stage.
//  A two-entry output register and skid stage hold results while rsp_ stalls;
//  req_tready drops only when both are full.
//  Synchronous active-high reset restores the register defaults and clears the
//  counters, trackers and both output entries.
`include "color_key_bounding_box_top_defines.svh"

module color_key_bounding_box_top (
   input  logic                              clock,
   input  logic                              reset,
   // pixel_blue [7:0], pixel_green [15:8], pixel_red [23:16]
   input  logic [ckbb_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // out_blue [7:0], out_green [15:8], out_red [23:16], box_left [34:24],
   // box_top [45:35], box_span_x [56:46], box_span_y [67:57], zero pad [71:68]
   output logic [ckbb_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // box_found [0]
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [ckbb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ckbb_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW = ckbb_pkg::COORD_W;
   localparam int SW = ckbb_pkg::SIZE_W;

   logic [ckbb_pkg::COMP_W-1:0] blue_below_ff, green_above_ff, red_above_ff;
   logic [SW-1:0]               width_ff, height_ff;

   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic [CW-1:0] min_col_ff, min_col_in, max_col_ff, max_col_in;
   logic [CW-1:0] min_row_ff, min_row_in, max_row_ff, max_row_in;
   logic          any_ff, any_in;

   ckbb_pkg::rsp_item_type out_ff, out_in, skid_ff, skid_in, item;
   logic                   out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic [ckbb_pkg::COMP_W-1:0] pix_b, pix_g, pix_r;
   logic [SW-1:0]  width_dec, height_dec;
   logic [CW-1:0]  col_last, row_last;
   logic [CW-1:0]  min_col_t, max_col_t, min_row_t, max_row_t;
   logic           hit, line_end, frame_end, accept, out_free;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         blue_below_ff  <= ckbb_pkg::BLUE_BELOW_RESET;
         green_above_ff <= ckbb_pkg::GREEN_ABOVE_RESET;
         red_above_ff   <= ckbb_pkg::RED_ABOVE_RESET;
         width_ff       <= ckbb_pkg::WIDTH_RESET;
         height_ff      <= ckbb_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (ckbb_pkg::csr_index_type'(csr_index))
            ckbb_pkg::REG_BLUE_BELOW:   blue_below_ff  <= csr_wdata[ckbb_pkg::COMP_W-1:0];
            ckbb_pkg::REG_GREEN_ABOVE:  green_above_ff <= csr_wdata[ckbb_pkg::COMP_W-1:0];
            ckbb_pkg::REG_RED_ABOVE:    red_above_ff   <= csr_wdata[ckbb_pkg::COMP_W-1:0];
            ckbb_pkg::REG_FRAME_WIDTH:  width_ff       <= csr_wdata[SW-1:0];
            ckbb_pkg::REG_FRAME_HEIGHT: height_ff      <= csr_wdata[SW-1:0];
            default: ;
         endcase
      end
   end

   // clamp frame size to 1..max and take the last column and row
   assign width_dec  = width_ff - SW'(1);
   assign height_dec = height_ff - SW'(1);

   always_comb begin
      if (width_ff == '0) begin
         col_last = '0;
      end else if (width_ff > SW'(ckbb_pkg::MAX_WIDTH)) begin
         col_last = CW'(ckbb_pkg::MAX_WIDTH - 1);
      end else begin
         col_last = width_dec[CW-1:0];
      end
      if (height_ff == '0) begin
         row_last = '0;
      end else if (height_ff > SW'(ckbb_pkg::MAX_HEIGHT)) begin
         row_last = CW'(ckbb_pkg::MAX_HEIGHT - 1);
      end else begin
         row_last = height_dec[CW-1:0];
      end
   end

   assign pix_b = req_tdata[7:0];
   assign pix_g = req_tdata[15:8];
   assign pix_r = req_tdata[23:16];

   assign hit = (pix_b < blue_below_ff) && (pix_g > green_above_ff)
                && (pix_r > red_above_ff);
   assign line_end  = col_ff >= col_last;
   assign frame_end = line_end && (row_ff >= row_last);

   // trackers including this pixel
   always_comb begin
      min_col_t = min_col_ff;
      max_col_t = max_col_ff;
      min_row_t = min_row_ff;
      max_row_t = max_row_ff;
      if (hit) begin
         if (!any_ff || col_ff < min_col_ff) min_col_t = col_ff;
         if (!any_ff || col_ff > max_col_ff) max_col_t = col_ff;
         if (!any_ff || row_ff < min_row_ff) min_row_t = row_ff;
         if (!any_ff || row_ff > max_row_ff) max_row_t = row_ff;
      end
   end

   always_comb begin
      item.blue   = hit ? '0 : pix_b;
      item.green  = hit ? '0 : pix_g;
      item.red    = hit ? '0 : pix_r;
      item.done   = frame_end;
      item.found  = frame_end && (any_ff || hit);
      item.left   = item.found ? min_col_t : '0;
      item.top    = item.found ? min_row_t : '0;
      item.span_x = item.found ? (max_col_t - min_col_t) : '0;
      item.span_y = item.found ? (max_row_t - min_row_t) : '0;
   end

   assign accept = req_tvalid && req_tready;

   // counters and trackers
   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      min_col_in = min_col_ff;
      max_col_in = max_col_ff;
      min_row_in = min_row_ff;
      max_row_in = max_row_ff;
      any_in     = any_ff;
      if (accept) begin
         if (frame_end) begin
            col_in     = '0;
            row_in     = '0;
            min_col_in = '1;
            max_col_in = '0;
            min_row_in = '1;
            max_row_in = '0;
            any_in     = 1'b0;
         end else begin
            min_col_in = min_col_t;
            max_col_in = max_col_t;
            min_row_in = min_row_t;
            max_row_in = max_row_t;
            any_in     = any_ff || hit;
            if (line_end) begin
               col_in = '0;
               row_in = row_ff + CW'(1);
            end else begin
               col_in = col_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         min_col_ff <= '1;
         max_col_ff <= '0;
         min_row_ff <= '1;
         max_row_ff <= '0;
         any_ff     <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         min_col_ff <= min_col_in;
         max_col_ff <= max_col_in;
         min_row_ff <= min_row_in;
         max_row_ff <= max_row_in;
         any_ff     <= any_in;
      end
   end

   // output register and skid stage
   assign req_tready = !skid_valid_ff;
   assign out_free   = !out_valid_ff || rsp_tready;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = item;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = item;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_ff.done;
   assign rsp_tuser  = out_ff.found;
   assign rsp_tdata  = {{ckbb_pkg::RSP_PAD_W{1'b0}}, out_ff.span_y, out_ff.span_x,
                        out_ff.top, out_ff.left, out_ff.red, out_ff.green, out_ff.blue};

   `CKBB_ASSERT_SAME(a_skid_behind_out, skid_valid_ff, out_valid_ff, "skid full with output empty")
   `CKBB_ASSERT_NEXT(a_stall_fills_skid, accept && out_valid_ff && !rsp_tready, skid_valid_ff, "stalled transfer not held in skid")
   `CKBB_ASSERT_SAME(a_idle_trackers, !any_ff, min_col_ff == '1 && max_col_ff == '0 && min_row_ff == '1 && max_row_ff == '0, "trackers moved without a match")
   `CKBB_ASSERT_SAME(a_box_only_on_last, rsp_tvalid && !rsp_tlast, !rsp_tuser && rsp_tdata[67:24] == '0, "box report outside frame end")

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Colour-key bounding box testbench
// Streams BGR pixels through the block under a range of thresholds, frame
// sizes and idle patterns on both channels. An in-bench model of the keying
// and the box tracking predicts every outgoing transfer, and each field of
// the pixel, the frame flag and the box report is compared in order.
// ---------------------------------------------------------------------------
module tb;

   localparam int COMP_W     = ckbb_pkg::COMP_W;
   localparam int COORD_W    = ckbb_pkg::COORD_W;
   localparam int SIZE_W     = ckbb_pkg::SIZE_W;
   localparam int CSR_IDX_W  = ckbb_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = ckbb_pkg::CSR_DATA_W;
   localparam int REQ_DATA_W = ckbb_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = ckbb_pkg::RSP_DATA_W;
   localparam int MAX_WIDTH  = ckbb_pkg::MAX_WIDTH;
   localparam int MAX_HEIGHT = ckbb_pkg::MAX_HEIGHT;

   localparam int CLOCK_HALF_NS = 6;
   localparam int RESET_CYCLES  = 7;
   localparam int QUIET_LIMIT   = 1000;
   localparam int PRINT_LIMIT   = 100;
   localparam int KEY_PCT       = 35;
   localparam int PHASE_PIXELS  = 95;
   localparam int OVERSIZE_PIXELS = 20;

   typedef struct {
      logic [COMP_W-1:0]  blue;
      logic [COMP_W-1:0]  green;
      logic [COMP_W-1:0]  red;
      logic               done;
      logic               found;
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] span_x;
      logic [COORD_W-1:0] span_y;
   } keyed_pixel_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // model copy of the registers and the frame trackers
   logic [COMP_W-1:0]  blue_below;
   logic [COMP_W-1:0]  green_above;
   logic [COMP_W-1:0]  red_above;
   logic [SIZE_W-1:0]  frame_width;
   logic [SIZE_W-1:0]  frame_height;
   logic [COORD_W-1:0] column_at;
   logic [COORD_W-1:0] row_at;
   logic [COORD_W-1:0] min_column;
   logic [COORD_W-1:0] max_column;
   logic [COORD_W-1:0] min_row;
   logic [COORD_W-1:0] max_row;
   logic               any_key;

   keyed_pixel_type pending_pixels[$];
   int unsigned     mismatches    = 0;
   int unsigned     req_idle_pct  = 0;
   int unsigned     rsp_stall_pct = 0;

   color_key_bounding_box_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #CLOCK_HALF_NS clock = 1'b1;
      #CLOCK_HALF_NS clock = 1'b0;
   end

   function automatic void clear_frame();
      column_at  = '0;
      row_at     = '0;
      min_column = '1;
      max_column = '0;
      min_row    = '1;
      max_row    = '0;
      any_key    = 1'b0;
   endfunction

   function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] v,
                                              input int unsigned maxv);
      if (v == '0) return 1;
      if (32'(v) > maxv) return maxv;
      return 32'(v);
   endfunction

   function automatic keyed_pixel_type key_pixel(input logic [COMP_W-1:0] b, g, r);
      keyed_pixel_type res;
      int unsigned     w;
      int unsigned     h;
      logic            hit;
      logic            line_end;
      w   = clamp_size(frame_width, MAX_WIDTH);
      h   = clamp_size(frame_height, MAX_HEIGHT);
      hit = (b < blue_below) && (g > green_above) && (r > red_above);
      if (hit) begin
         if (!any_key || column_at < min_column) min_column = column_at;
         if (!any_key || column_at > max_column) max_column = column_at;
         if (!any_key || row_at < min_row) min_row = row_at;
         if (!any_key || row_at > max_row) max_row = row_at;
         any_key = 1'b1;
      end
      res = '{default: '0};
      res.blue  = hit ? '0 : b;
      res.green = hit ? '0 : g;
      res.red   = hit ? '0 : r;
      line_end  = 32'(column_at) >= w - 1;
      if (line_end && 32'(row_at) >= h - 1) begin
         res.done = 1'b1;
         if (any_key) begin
            res.found  = 1'b1;
            res.left   = min_column;
            res.top    = min_row;
            res.span_x = max_column - min_column;
            res.span_y = max_row - min_row;
         end
         clear_frame();
      end else if (line_end) begin
         column_at = '0;
         row_at    = row_at + COORD_W'(1);
      end else begin
         column_at = column_at + COORD_W'(1);
      end
      return res;
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("mismatch at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want) flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // leaves csr_we high; the caller drops it after the last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         ckbb_pkg::REG_BLUE_BELOW:   blue_below   = value[COMP_W-1:0];
         ckbb_pkg::REG_GREEN_ABOVE:  green_above  = value[COMP_W-1:0];
         ckbb_pkg::REG_RED_ABOVE:    red_above    = value[COMP_W-1:0];
         ckbb_pkg::REG_FRAME_WIDTH:  frame_width  = value;
         ckbb_pkg::REG_FRAME_HEIGHT: frame_height = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_frame(input logic [CSR_DATA_W-1:0] bb, ga, ra, w, h);
      write_reg(ckbb_pkg::REG_BLUE_BELOW, bb);
      write_reg(ckbb_pkg::REG_GREEN_ABOVE, ga);
      write_reg(ckbb_pkg::REG_RED_ABOVE, ra);
      write_reg(ckbb_pkg::REG_FRAME_WIDTH, w);
      write_reg(ckbb_pkg::REG_FRAME_HEIGHT, h);
      csr_we <= 1'b0;
   endtask

   // leaves req_tvalid high so back-to-back pixels stream without a gap
   task automatic send_pixel(input logic [COMP_W-1:0] b, g, r);
      while ($urandom_range(99, 0) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= {r, g, b};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_pixels.push_back(key_pixel(b, g, r));
   endtask

   task automatic send_random_pixel(input int unsigned key_pct);
      logic [COMP_W-1:0] b;
      logic [COMP_W-1:0] g;
      logic [COMP_W-1:0] r;
      b = COMP_W'($urandom_range(255, 0));
      g = COMP_W'($urandom_range(255, 0));
      r = COMP_W'($urandom_range(255, 0));
      if ($urandom_range(99, 0) < key_pct && blue_below != '0 &&
          green_above != '1 && red_above != '1) begin
         b = COMP_W'($urandom_range(int'(blue_below) - 1, 0));
         g = COMP_W'($urandom_range(255, int'(green_above) + 1));
         r = COMP_W'($urandom_range(255, int'(red_above) + 1));
      end
      send_pixel(b, g, r);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // bring the counters back to the top of a frame
   task automatic flush_frame();
      set_frame(CSR_DATA_W'(blue_below), CSR_DATA_W'(green_above),
                CSR_DATA_W'(red_above), 12'd1, 12'd1);
      send_random_pixel(50);
      settle();
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_threshold();
      logic [COMP_W-1:0] v;
      case ($urandom_range(5, 0))
         0: v = '0;
         1: v = '1;
         default: v = COMP_W'($urandom_range(254, 1));
      endcase
      return {4'($urandom_range(15, 0)), v};
   endfunction

   task automatic test_reset_config();
      send_pixel('0, '1, '1);
      send_pixel(8'd100, 8'd131, 8'd171);
      send_pixel(8'd99, 8'd131, 8'd171);
      send_pixel(8'd99, 8'd130, 8'd171);
      send_pixel(8'd99, 8'd131, 8'd170);
      send_pixel('1, '0, '0);
      settle();
   endtask

   task automatic test_threshold_extremes();
      flush_frame();
      set_frame(12'h000, 12'h0FF, 12'h0FF, 12'd2, 12'd1);
      send_pixel('0, '1, '1);
      send_pixel('1, '1, '1);
      settle();
      set_frame(12'hFFF, 12'hF00, 12'h000, 12'd3, 12'd2);
      // writes past the register list must leave the settings alone
      for (int i = ckbb_pkg::REG_FRAME_HEIGHT + 1; i < (1 << CSR_IDX_W); i++)
         write_reg(CSR_IDX_W'(i), '0);
      csr_we <= 1'b0;
      send_pixel(8'd254, 8'd1, 8'd1);
      send_pixel('1, 8'd1, 8'd1);
      send_pixel('0, '0, '1);
      send_pixel('0, '1, '0);
      send_pixel('0, '1, '1);
      send_pixel(8'd7, 8'd9, 8'd9);
      settle();
   endtask

   task automatic test_frame_size_zero();
      set_frame(CSR_DATA_W'(ckbb_pkg::BLUE_BELOW_RESET),
                CSR_DATA_W'(ckbb_pkg::GREEN_ABOVE_RESET),
                CSR_DATA_W'(ckbb_pkg::RED_ABOVE_RESET), '0, '0);
      send_pixel('0, '1, '1);
      send_pixel('1, '0, '0);
      settle();
   endtask

   task automatic test_size_change_mid_frame();
      set_frame(CSR_DATA_W'(ckbb_pkg::BLUE_BELOW_RESET),
                CSR_DATA_W'(ckbb_pkg::GREEN_ABOVE_RESET),
                CSR_DATA_W'(ckbb_pkg::RED_ABOVE_RESET), 12'd8, 12'd4);
      repeat (5) send_pixel('1, '0, '0);
      settle();
      // column counter now sits past the new last column
      set_frame(CSR_DATA_W'(ckbb_pkg::BLUE_BELOW_RESET),
                CSR_DATA_W'(ckbb_pkg::GREEN_ABOVE_RESET),
                CSR_DATA_W'(ckbb_pkg::RED_ABOVE_RESET), 12'd2, 12'd2);
      send_pixel('0, '1, '1);
      send_pixel('1, '0, '0);
      send_pixel('0, '1, '1);
      settle();
   endtask

   // sizes above the maximum hold at the maximum and never wrap short
   task automatic test_largest_frame();
      flush_frame();
      set_frame(CSR_DATA_W'(ckbb_pkg::BLUE_BELOW_RESET),
                CSR_DATA_W'(ckbb_pkg::GREEN_ABOVE_RESET),
                CSR_DATA_W'(ckbb_pkg::RED_ABOVE_RESET), 12'h801, 12'h801);
      repeat (OVERSIZE_PIXELS) send_random_pixel(KEY_PCT);
      settle();
      set_frame(CSR_DATA_W'(ckbb_pkg::BLUE_BELOW_RESET),
                CSR_DATA_W'(ckbb_pkg::GREEN_ABOVE_RESET),
                CSR_DATA_W'(ckbb_pkg::RED_ABOVE_RESET), 12'd1, 12'h801);
      repeat (OVERSIZE_PIXELS) send_random_pixel(KEY_PCT);
      settle();
      set_frame(CSR_DATA_W'(ckbb_pkg::BLUE_BELOW_RESET),
                CSR_DATA_W'(ckbb_pkg::GREEN_ABOVE_RESET),
                CSR_DATA_W'(ckbb_pkg::RED_ABOVE_RESET), '1, '1);
      repeat (OVERSIZE_PIXELS) send_random_pixel(KEY_PCT);
      settle();
      flush_frame();
   endtask

   // whole frames with random content, then a partial one left hanging
   task automatic run_random_phase(input int unsigned count);
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
      int unsigned       area;
      int unsigned       sent;
      settle();
      w = ($urandom_range(7, 0) == 0) ? '0 : SIZE_W'($urandom_range(8, 1));
      h = ($urandom_range(7, 0) == 0) ? '0 : SIZE_W'($urandom_range(6, 1));
      set_frame(random_threshold(), random_threshold(), random_threshold(), w, h);
      area = clamp_size(w, MAX_WIDTH) * clamp_size(h, MAX_HEIGHT);
      sent = 0;
      while (sent + area <= count) begin
         repeat (area) send_random_pixel(KEY_PCT);
         sent += area;
      end
      repeat (count - sent) send_random_pixel(KEY_PCT);
   endtask

   task automatic test_random_frames();
      for (int mode = 0; mode < 4; mode++) begin
         req_idle_pct  = (mode == 1) ? 45 : (mode == 3) ? 24 : 0;
         rsp_stall_pct = (mode == 2) ? 45 : (mode == 3) ? 24 : 0;
         repeat (4) run_random_phase(PHASE_PIXELS);
      end
      settle();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
   endtask

   always @(posedge clock) begin
      keyed_pixel_type want;
      rsp_tready <= ($urandom_range(99, 0) >= rsp_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            flag_mismatch("transfer out with no pixel outstanding");
         end else begin
            want = pending_pixels.pop_front();
            check_field("out_blue", 32'(rsp_tdata[7:0]), 32'(want.blue));
            check_field("out_green", 32'(rsp_tdata[15:8]), 32'(want.green));
            check_field("out_red", 32'(rsp_tdata[23:16]), 32'(want.red));
            check_field("box_left", 32'(rsp_tdata[34:24]), 32'(want.left));
            check_field("box_top", 32'(rsp_tdata[45:35]), 32'(want.top));
            check_field("box_span_x", 32'(rsp_tdata[56:46]), 32'(want.span_x));
            check_field("box_span_y", 32'(rsp_tdata[67:57]), 32'(want.span_y));
            check_field("pad", 32'(rsp_tdata[71:68]), 0);
            check_field("box_found", 32'(rsp_tuser), 32'(want.found));
            check_field("frame_done", 32'(rsp_tlast), 32'(want.done));
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      blue_below   = ckbb_pkg::BLUE_BELOW_RESET;
      green_above  = ckbb_pkg::GREEN_ABOVE_RESET;
      red_above    = ckbb_pkg::RED_ABOVE_RESET;
      frame_width  = ckbb_pkg::WIDTH_RESET;
      frame_height = ckbb_pkg::HEIGHT_RESET;
      clear_frame();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_config();
      test_threshold_extremes();
      test_frame_size_zero();
      test_size_change_mid_frame();
      test_largest_frame();
      test_random_frames();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
